### hdl/uncertainty_arithmetic_unit_macros.svh
// Assertion macros used by the uncertainty arithmetic unit top level.
`ifndef UNCERTAINTY_ARITHMETIC_UNIT_MACROS_SVH
`define UNCERTAINTY_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/uau_pkg.sv
// Types, constants and helper functions of the uncertainty arithmetic unit.
`default_nettype none
package uau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int MAG_W     = 32;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int NUM_W     = PROD_W + FRAC_BITS;
    localparam int Q_W       = 32;
    localparam int HI_W      = NUM_W - Q_W;
    localparam int REM_W     = PROD_W + 1;
    localparam int DIV_STAGES = Q_W;

    localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(64'h0000_0000_8000_0000);
    localparam logic [PROD_W-1:0] POS_LIM = PROD_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [PROD_W-1:0] OVF_MAG = PROD_W'(64'h0000_0100_0000_0000);

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_MUL   = 3'd2,
        ACT_DIV   = 3'd3,
        ACT_SCALE = 3'd4,
        ACT_SDIV  = 3'd5
    } t_act;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } t_sm;

    typedef struct packed {
        logic is_div;
        logic divz;
        t_sm  cv;
        t_sm  cd;
    } t_ctl;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [PROD_W-1:0] den;
        logic [Q_W-1:0]    low;
        logic [Q_W-1:0]    quo;
        logic              ovf;
    } t_div;

    function automatic t_sm sm_add(t_sm x, t_sm y);
        t_sm r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        return r;
    endfunction

    // Divider setup: quotient fits Q_W bits unless ovf.
    function automatic t_div div_init(logic [PROD_W-1:0] n, logic [PROD_W-1:0] d);
        t_div             r;
        logic [NUM_W-1:0] num;
        logic [HI_W-1:0]  hi;
        num   = NUM_W'(n) << FRAC_BITS;
        hi    = num[NUM_W-1:Q_W];
        r.ovf = NUM_W'(hi) >= NUM_W'(d);
        r.rem = REM_W'(hi);
        r.den = d;
        r.low = num[Q_W-1:0];
        r.quo = '0;
        return r;
    endfunction

    // Returns {saturated, value}.
    function automatic logic [DATA_W:0] sat32(t_sm s);
        logic              flag;
        logic [DATA_W-1:0] val;
        flag = 1'b0;
        if (s.neg) begin
            if (s.mag > NEG_LIM) begin
                flag = 1'b1;
                val  = NEG_LIM[DATA_W-1:0];
            end else begin
                val = DATA_W'(-s.mag[DATA_W-1:0]);
            end
        end else begin
            if (s.mag > POS_LIM) begin
                flag = 1'b1;
                val  = POS_LIM[DATA_W-1:0];
            end else begin
                val = s.mag[DATA_W-1:0];
            end
        end
        return {flag, val};
    endfunction

endpackage
`default_nettype wire

### hdl/uau_in_if.sv
// Input channel: action code and two operands with uncertainties.
`default_nettype none
interface uau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] a_value;
    logic signed [31:0] a_delta;
    logic signed [31:0] b_value;
    logic signed [31:0] b_delta;

    modport source (output valid, action, a_value, a_delta, b_value, b_delta, input ready);
    modport sink   (input valid, action, a_value, a_delta, b_value, b_delta, output ready);
endinterface
`default_nettype wire

### hdl/uau_out_if.sv
// Output channel: result value, uncertainty and status.
`default_nettype none
interface uau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] c_value;
    logic signed [31:0] c_delta;
    logic [1:0]         status;

    modport source (output valid, c_value, c_delta, status, input ready);
    modport sink   (input valid, c_value, c_delta, status, output ready);
endinterface
`default_nettype wire

### hdl/uncertainty_arithmetic_unit.sv
// Top level: linear error propagation arithmetic on Q16.16 operand pairs.
//
//   channel  dir  transaction payload
//   i_in     in   action, a_value, a_delta, b_value, b_delta
//   o_out    out  c_value, c_delta, status
//
// 4 front stages (decode, 32x32 products, sums, divider setup), 32
// restoring-division stages of one quotient bit each, output register. One
// transaction per cycle unless stalled. Whole pipeline advances when the output
// register is empty or taken; i_in.ready follows that. Sync reset clears valids.
`default_nettype none
`include "uncertainty_arithmetic_unit_macros.svh"
module uncertainty_arithmetic_unit (
    input wire logic i_clk,
    input wire logic i_rst_n,
    uau_in_if.sink   i_in,
    uau_out_if.source o_out
);
    localparam int NS = uau_pkg::DIV_STAGES;
    localparam int DW = uau_pkg::DATA_W;
    localparam int PW = uau_pkg::PROD_W;

    logic r_out_valid;
    logic w_en;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    logic          w_valid [0:NS];
    uau_pkg::t_ctl w_ctl   [0:NS];
    uau_pkg::t_div w_v     [0:NS];
    uau_pkg::t_div w_d     [0:NS];

    uau_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in.valid),
        .i_action  (i_in.action),
        .i_a_value (i_in.a_value),
        .i_a_delta (i_in.a_delta),
        .i_b_value (i_in.b_value),
        .i_b_delta (i_in.b_delta),
        .o_valid   (w_valid[0]),
        .o_ctl     (w_ctl[0]),
        .o_v       (w_v[0]),
        .o_d       (w_d[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_div
        uau_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_ctl   (w_ctl[g]),
            .i_v     (w_v[g]),
            .i_d     (w_d[g]),
            .o_valid (w_valid[g+1]),
            .o_ctl   (w_ctl[g+1]),
            .o_v     (w_v[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    uau_pkg::t_ctl    w_last;
    uau_pkg::t_sm     w_cv, w_cd;
    logic [DW:0]      w_sv, w_sd;
    logic [DW-1:0]    n_value, n_delta;
    uau_pkg::t_status n_status;

    always_comb begin
        w_last = w_ctl[NS];
        w_cv   = w_last.cv;
        w_cd   = w_last.cd;
        if (w_last.is_div) begin
            w_cv.mag = w_v[NS].ovf ? uau_pkg::OVF_MAG : PW'(w_v[NS].quo);
            w_cd.mag = w_d[NS].ovf ? uau_pkg::OVF_MAG : PW'(w_d[NS].quo);
        end
        w_sv = uau_pkg::sat32(w_cv);
        w_sd = uau_pkg::sat32(w_cd);
        if (w_last.divz) begin
            n_value  = '0;
            n_delta  = '0;
            n_status = uau_pkg::ST_DIVZ;
        end else begin
            n_value  = w_sv[DW-1:0];
            n_delta  = w_sd[DW-1:0];
            n_status = (w_sv[DW] || w_sd[DW]) ? uau_pkg::ST_SAT : uau_pkg::ST_OK;
        end
    end

    logic [DW-1:0]    r_value, r_delta;
    uau_pkg::t_status r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value  <= n_value;
            r_delta  <= n_delta;
            r_status <= n_status;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.c_value = r_value;
    assign o_out.c_delta = r_delta;
    assign o_out.status  = r_status;

    `UAU_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out.valid, i_in.ready, "input stalled with empty output")
    `UAU_ASSERT_NOW(a_divz_zero, i_clk, i_rst_n, o_out.valid && o_out.status == uau_pkg::ST_DIVZ, o_out.c_value == '0 && o_out.c_delta == '0, "divide by zero with nonzero result")
    `UAU_ASSERT_NOW(a_sat_limit, i_clk, i_rst_n, o_out.valid && o_out.status == uau_pkg::ST_SAT, o_out.c_value == 32'sh7FFF_FFFF || o_out.c_value == 32'sh8000_0000 || o_out.c_delta == 32'sh7FFF_FFFF || o_out.c_delta == 32'sh8000_0000, "saturated status without a limit value")
    `UAU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid, "pending result dropped")
endmodule
`default_nettype wire

### hdl/uau_front.sv
// Front pipeline: decode, products, propagation sums and divider setup.
`default_nettype none
module uau_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [2:0]         i_action,
    input  wire logic signed [31:0] i_a_value,
    input  wire logic signed [31:0] i_a_delta,
    input  wire logic signed [31:0] i_b_value,
    input  wire logic signed [31:0] i_b_delta,
    output      logic               o_valid,
    output      uau_pkg::t_ctl      o_ctl,
    output      uau_pkg::t_div      o_v,
    output      uau_pkg::t_div      o_d
);
    localparam int MW = uau_pkg::MAG_W;
    localparam int PW = uau_pkg::PROD_W;
    localparam int FB = uau_pkg::FRAC_BITS;

    // stage 1: sign/magnitude
    logic          r1_valid;
    uau_pkg::t_act r1_act;
    logic          r1_an, r1_dan, r1_bn, r1_dbn;
    logic [MW-1:0] r1_am, r1_dam, r1_bm, r1_dbm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_act <= uau_pkg::t_act'(i_action);
            r1_an  <= i_a_value[31];
            r1_dan <= i_a_delta[31];
            r1_bn  <= i_b_value[31];
            r1_dbn <= i_b_delta[31];
            r1_am  <= i_a_value[31] ? MW'(-i_a_value) : MW'(i_a_value);
            r1_dam <= i_a_delta[31] ? MW'(-i_a_delta) : MW'(i_a_delta);
            r1_bm  <= i_b_value[31] ? MW'(-i_b_value) : MW'(i_b_value);
            r1_dbm <= i_b_delta[31] ? MW'(-i_b_delta) : MW'(i_b_delta);
        end
    end

    // stage 2: products
    logic          r2_valid;
    uau_pkg::t_act r2_act;
    logic          r2_an, r2_dan, r2_bn, r2_dbn;
    logic [MW-1:0] r2_am, r2_dam, r2_bm, r2_dbm;
    logic [PW-1:0] r2_p_ab, r2_p_dab, r2_p_adb, r2_p_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_act   <= r1_act;
            r2_an    <= r1_an;
            r2_dan   <= r1_dan;
            r2_bn    <= r1_bn;
            r2_dbn   <= r1_dbn;
            r2_am    <= r1_am;
            r2_dam   <= r1_dam;
            r2_bm    <= r1_bm;
            r2_dbm   <= r1_dbm;
            r2_p_ab  <= PW'(r1_am)  * PW'(r1_bm);
            r2_p_dab <= PW'(r1_dam) * PW'(r1_bm);
            r2_p_adb <= PW'(r1_am)  * PW'(r1_dbm);
            r2_p_bb  <= PW'(r1_bm)  * PW'(r1_bm);
        end
    end

    // stage 3: sums, direct results and divider operands
    uau_pkg::t_ctl n_ctl;
    logic [PW-1:0] n_vn, n_vd, n_dn, n_dd;
    uau_pkg::t_sm  w_num, w_a, w_b, w_da, w_db;

    always_comb begin
        w_a   = '{neg: r2_an,  mag: PW'(r2_am)};
        w_b   = '{neg: r2_bn,  mag: PW'(r2_bm)};
        w_da  = '{neg: r2_dan, mag: PW'(r2_dam)};
        w_db  = '{neg: r2_dbn, mag: PW'(r2_dbm)};
        w_num = uau_pkg::sm_add('{neg: r2_dan ^ r2_bn, mag: r2_p_dab},
                                '{neg: r2_an ^ r2_dbn, mag: r2_p_adb});
        n_ctl.is_div = 1'b0;
        n_ctl.divz   = 1'b0;
        n_ctl.cv     = '{neg: 1'b0, mag: '0};
        n_ctl.cd     = '{neg: 1'b0, mag: '0};
        n_vn = PW'(r2_am);
        n_vd = PW'(r2_bm);
        n_dn = PW'(r2_dam);
        n_dd = PW'(r2_bm);
        case (r2_act)
            uau_pkg::ACT_ADD: begin
                n_ctl.cv = uau_pkg::sm_add(w_a, w_b);
                n_ctl.cd = uau_pkg::sm_add(w_da, w_db);
            end
            uau_pkg::ACT_SUB: begin
                n_ctl.cv = uau_pkg::sm_add(w_a, '{neg: !r2_bn, mag: PW'(r2_bm)});
                n_ctl.cd = uau_pkg::sm_add(w_da, w_db);
            end
            uau_pkg::ACT_MUL: begin
                n_ctl.cv = '{neg: r2_an ^ r2_bn, mag: r2_p_ab >> FB};
                n_ctl.cd = '{neg: w_num.neg, mag: w_num.mag >> FB};
            end
            uau_pkg::ACT_DIV: begin
                n_ctl.is_div = 1'b1;
                n_ctl.divz   = (r2_bm == '0);
                n_ctl.cv.neg = r2_an ^ r2_bn;
                n_ctl.cd.neg = w_num.neg;
                n_dn = w_num.mag;
                n_dd = r2_p_bb;
            end
            uau_pkg::ACT_SCALE: begin
                n_ctl.cv = '{neg: r2_an ^ r2_bn, mag: r2_p_ab >> FB};
                n_ctl.cd = '{neg: r2_dan ^ r2_bn, mag: r2_p_dab >> FB};
            end
            uau_pkg::ACT_SDIV: begin
                n_ctl.is_div = 1'b1;
                n_ctl.divz   = (r2_bm == '0);
                n_ctl.cv.neg = r2_an ^ r2_bn;
                n_ctl.cd.neg = r2_dan ^ r2_bn;
            end
            default: begin
            end
        endcase
    end

    logic          r3_valid;
    uau_pkg::t_ctl r3_ctl;
    logic [PW-1:0] r3_vn, r3_vd, r3_dn, r3_dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ctl <= n_ctl;
            r3_vn  <= n_vn;
            r3_vd  <= n_vd;
            r3_dn  <= n_dn;
            r3_dd  <= n_dd;
        end
    end

    // stage 4: divider setup and range check
    logic          r4_valid;
    uau_pkg::t_ctl r4_ctl;
    uau_pkg::t_div r4_v, r4_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ctl <= r3_ctl;
            r4_v   <= uau_pkg::div_init(r3_vn, r3_vd);
            r4_d   <= uau_pkg::div_init(r3_dn, r3_dd);
        end
    end

    assign o_valid = r4_valid;
    assign o_ctl   = r4_ctl;
    assign o_v     = r4_v;
    assign o_d     = r4_d;
endmodule
`default_nettype wire

### hdl/uau_div_stage.sv
// One restoring-division stage: one quotient bit for each of two lanes.
`default_nettype none
module uau_div_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire uau_pkg::t_ctl i_ctl,
    input  wire uau_pkg::t_div i_v,
    input  wire uau_pkg::t_div i_d,
    output      logic          o_valid,
    output      uau_pkg::t_ctl o_ctl,
    output      uau_pkg::t_div o_v,
    output      uau_pkg::t_div o_d
);
    localparam int RW = uau_pkg::REM_W;
    localparam int QW = uau_pkg::Q_W;

    function automatic uau_pkg::t_div step(uau_pkg::t_div x);
        uau_pkg::t_div r;
        logic [RW-1:0] rem2;
        logic          bit_q;
        rem2  = {x.rem[RW-2:0], x.low[QW-1]};
        bit_q = rem2 >= RW'(x.den);
        r     = x;
        r.rem = bit_q ? rem2 - RW'(x.den) : rem2;
        r.low = {x.low[QW-2:0], 1'b0};
        r.quo = {x.quo[QW-2:0], bit_q};
        return r;
    endfunction

    logic          r_valid;
    uau_pkg::t_ctl r_ctl;
    uau_pkg::t_div r_v, r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_v   <= step(i_v);
            r_d   <= step(i_d);
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_v     = r_v;
    assign o_d     = r_d;
endmodule
`default_nettype wire
